[sv/blpf_pkg.sv]
// ----------------------------------------------------------------------------
// blpf_pkg
// Shared widths, command and status codes, and the perfect-number test.
// ----------------------------------------------------------------------------
`default_nettype none

package blpf_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_FIND    = 3'd3,
    CMD_DELPERF = 3'd4,
    CMD_READ    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Every perfect number that fits in a positive signed 32-bit value.
  function automatic logic is_perfect(input logic [VALUE_W-1:0] v);
    return (v == 32'd6) || (v == 32'd28) || (v == 32'd496) ||
           (v == 32'd8128) || (v == 32'd33550336);
  endfunction

endpackage

`default_nettype wire

[sv/blpf_if.sv]
// ----------------------------------------------------------------------------
// blpf_req_if / blpf_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface blpf_req_if;
  import blpf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;
  modport source (output valid, cmd, value, index, input ready);
  modport sink (input valid, cmd, value, index, output ready);
endinterface

interface blpf_rsp_if;
  import blpf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [INDEX_W-1:0]        found_index;
  logic signed [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]        entry_count;
  logic [COUNT_W-1:0]        removed_count;
  modport source (output valid, status, found_index, read_value, entry_count,
                  removed_count, input ready);
  modport sink (input valid, status, found_index, read_value, entry_count,
                removed_count, output ready);
endinterface

`default_nettype wire

[sv/bounded_list_with_perfect_filter.sv]
// ----------------------------------------------------------------------------
// bounded_list_with_perfect_filter
// Ordered list of signed 32-bit numbers with a perfect-number filter.
// ----------------------------------------------------------------------------
// One item is taken at a time; the list lives in a single-port-read RAM and
// a sequencer walks it one entry at a time (read, then act). Insert and
// remove shift the entries behind the position, find walks the list until
// a match, and delete-perfect walks every entry held.
// A result waits in an output register, so the next item is taken as soon as
// the sequencer is back in idle.
`default_nettype none

module bounded_list_with_perfect_filter #(
  parameter int unsigned CAPACITY = blpf_pkg::CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  blpf_req_if.sink req,
  blpf_rsp_if.source rsp
);
  import blpf_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > INDEX_W + 1) ? CW : INDEX_W + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_FIN  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        rptr;
  logic [AW-1:0]        wptr;
  cmd_t                 cmd_q;
  logic [VALUE_W-1:0]   val_q;
  logic [INDEX_W-1:0]   idx_q;
  status_t              st_q;
  logic [INDEX_W-1:0]   found_q;
  logic [VALUE_W-1:0]   rdv_q;
  logic [CW-1:0]        removed_q;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [INDEX_W-1:0]   out_found;
  logic [VALUE_W-1:0]   out_rdv;
  logic [COUNT_W-1:0]   out_count;
  logic [COUNT_W-1:0]   out_removed;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [VALUE_W-1:0]   wdata;
  logic [VALUE_W-1:0]   q;
  logic                 perf;
  logic                 last;
  logic [XW-1:0]        idx_x;
  logic [XW-1:0]        cnt_x;

  assign idx_x = XW'(req.index);
  assign cnt_x = XW'(count);
  assign perf  = is_perfect(q);
  assign last  = (XW'(rptr) + XW'(1)) == cnt_x;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = wptr;
    wdata = q;
    if (state == S_FIN) begin
      we    = 1'b1;
      wdata = val_q;
    end else if (state == S_WR) begin
      case (cmd_q)
        CMD_INSERT: begin
          we    = 1'b1;
          waddr = rptr + AW'(1);
        end
        CMD_REMOVE: begin
          we    = 1'b1;
          waddr = rptr - AW'(1);
        end
        CMD_DELPERF: begin
          we = !perf;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  blpf_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rptr),
    .rdata (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q     <= cmd_t'(req.cmd);
            val_q     <= req.value;
            idx_q     <= req.index;
            st_q      <= ST_OK;
            found_q   <= '0;
            rdv_q     <= '0;
            removed_q <= '0;
            state     <= S_DONE;
            case (cmd_t'(req.cmd))
              CMD_APPEND: begin
                if (count >= CW'(CAPACITY)) begin
                  st_q <= ST_FULL;
                end else begin
                  wptr  <= AW'(count);
                  state <= S_FIN;
                end
              end
              CMD_INSERT: begin
                if (count >= CW'(CAPACITY)) begin
                  st_q <= ST_FULL;
                end else if (idx_x >= cnt_x) begin
                  st_q <= ST_BADPOS;
                end else begin
                  wptr <= AW'(idx_x + XW'(1));
                  if (idx_x + XW'(1) < cnt_x) begin
                    rptr  <= AW'(cnt_x - XW'(1));
                    state <= S_RD;
                  end else begin
                    state <= S_FIN;
                  end
                end
              end
              CMD_REMOVE: begin
                if (count == '0) begin
                  st_q <= ST_EMPTY;
                end else if (idx_x >= cnt_x) begin
                  st_q <= ST_BADPOS;
                end else if (idx_x + XW'(1) < cnt_x) begin
                  rptr  <= AW'(idx_x + XW'(1));
                  state <= S_RD;
                end else begin
                  count <= count - CW'(1);
                end
              end
              CMD_FIND: begin
                st_q <= ST_NOTFOUND;
                if (count != '0) begin
                  rptr  <= '0;
                  state <= S_RD;
                end
              end
              CMD_DELPERF: begin
                if (count == '0) begin
                  st_q <= ST_EMPTY;
                end else begin
                  rptr  <= '0;
                  wptr  <= '0;
                  state <= S_RD;
                end
              end
              CMD_READ: begin
                if (count == '0) begin
                  st_q <= ST_EMPTY;
                end else if (idx_x >= cnt_x) begin
                  st_q <= ST_BADPOS;
                end else begin
                  rptr  <= AW'(idx_x);
                  state <= S_RD;
                end
              end
              default: begin
                st_q <= ST_OK;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          state <= S_RD;
          case (cmd_q)
            CMD_INSERT: begin
              if (XW'(rptr) == XW'(idx_q) + XW'(1)) begin
                state <= S_FIN;
              end else begin
                rptr <= rptr - AW'(1);
              end
            end
            CMD_REMOVE: begin
              if (last) begin
                count <= count - CW'(1);
                state <= S_DONE;
              end else begin
                rptr <= rptr + AW'(1);
              end
            end
            CMD_FIND: begin
              if (q == val_q) begin
                st_q    <= ST_OK;
                found_q <= INDEX_W'(rptr);
                state   <= S_DONE;
              end else if (last) begin
                state <= S_DONE;
              end else begin
                rptr <= rptr + AW'(1);
              end
            end
            CMD_DELPERF: begin
              if (perf) begin
                removed_q <= removed_q + CW'(1);
              end else begin
                wptr <= wptr + AW'(1);
              end
              if (last) begin
                count <= CW'(wptr) + CW'(!perf);
                state <= S_DONE;
              end else begin
                rptr <= rptr + AW'(1);
              end
            end
            default: begin
              rdv_q <= q;
              state <= S_DONE;
            end
          endcase
        end
        S_FIN: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_status  <= st_q;
            out_found   <= found_q;
            out_rdv     <= rdv_q;
            out_count   <= COUNT_W'(count);
            out_removed <= COUNT_W'(removed_q);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.found_index   = out_found;
  assign rsp.read_value    = out_rdv;
  assign rsp.entry_count   = out_count;
  assign rsp.removed_count = out_removed;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("Sequencer stayed idle after taking an item.");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |=> state == S_WR)
    else $error("Read step not followed by its act step.");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!out_valid || rsp.ready) |=> out_valid && state == S_IDLE)
    else $error("Finished item not moved to the output register.");

endmodule

`default_nettype wire

[sv/blpf_ram.sv]
// ----------------------------------------------------------------------------
// blpf_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blpf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
